// ----- design/vlne_pkg.sv -----
// shared types and constants of the variable-length number encoder
package vlne_pkg;

    localparam int VALUE_W   = 64;
    localparam int MAX_BYTES = 8;
    localparam int LEN_W     = 4;

    typedef logic [7:0]       byte_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam byte_t SMALL_MAX  = 8'd127;
    localparam byte_t HEAD_PLAIN = 8'h80;
    localparam byte_t HEAD_FILL  = 8'hC0;
    localparam byte_t FILL_BYTE  = 8'hFF;
    localparam byte_t ZERO_BYTE  = 8'h00;

    // head byte and number of data bytes that follow it
    typedef struct packed {
        byte_t head;
        len_t  len;
    } vlne_plan_t;

endpackage

// ----- design/vlne_if.sv -----
// valid/ready channel interfaces of the encoder
interface vlne_item_if;
    logic                              valid;
    logic                              ready;
    logic signed [vlne_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface vlne_result_if;
    logic                valid;
    logic                ready;
    logic [7:0]          out_byte;
    logic                last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface vlne_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/var_length_number_encoder_unit.sv -----
// top level of the variable-length number encoder
// Each accepted number is sent as its length-prefixed little-endian encoding on the result
// channel, one byte per transaction with last set on the final byte: one byte for 0..127,
// otherwise a head byte and 1 to VALUE_BYTES data bytes, so an item takes 1 to
// VALUE_BYTES+1 result transactions, and that byte-wide output register sets the sustained
// rate. The first byte passes through the input register and then the output register
// before it is offered on the result channel. An input register holds the next number
// while the current one is still being sent, so a new number is taken as soon as the last
// byte of the previous one leaves. compact_reg is set over the cfg channel, which is
// always ready; the user must write it only while the block is idle; it is not enforced.
module var_length_number_encoder_unit #(
    parameter int VALUE_BYTES = vlne_pkg::MAX_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    vlne_item_if.sink     item,
    vlne_result_if.source result,
    vlne_cfg_if.sink      cfg
);

    logic                     compact_reg;
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [VALUE_BYTES*8-1:0] in_value_reg;
    logic                     load_ok;
    logic                     load_take;
    vlne_pkg::vlne_plan_t     plan;

    assign cfg.ready  = 1'b1;
    assign item.ready = !in_valid_reg || load_ok;
    assign load_take  = in_valid_reg && load_ok;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item.valid && item.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (load_take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compact_reg  <= 1'b0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg.valid)
            begin
                compact_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_value_reg <= item.value[VALUE_BYTES*8-1:0];
        end
    end

    vlne_analyzer #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_analyzer (
        .value   (in_value_reg),
        .compact (compact_reg),
        .plan    (plan)
    );

    vlne_serializer #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid_reg),
        .load_value (in_value_reg),
        .load_plan  (plan),
        .load_ok    (load_ok),
        .result     (result)
    );

    // a waiting number stays until the serializer takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !load_ok) |=> in_valid_reg)
    else $error("waiting number dropped");

    // a taken number shows up on the result channel next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_take |=> result.valid)
    else $error("loaded number not presented");

    // a byte that is not last is always followed by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.last) |=> result.valid)
    else $error("encoding cut short");

endmodule

// ----- design/vlne_analyzer.sv -----
// works out the head byte and data byte count of one number
module vlne_analyzer #(
    parameter int VALUE_BYTES = vlne_pkg::MAX_BYTES
) (
    input  logic [VALUE_BYTES*8-1:0] value,
    input  logic                     compact,
    output vlne_pkg::vlne_plan_t     plan
);

    logic            is_short;
    vlne_pkg::len_t  s;
    vlne_pkg::len_t  u;
    vlne_pkg::byte_t b;

    always_comb
    begin
        is_short = (value[7:0] <= vlne_pkg::SMALL_MAX);
        for (int i = 1; i < VALUE_BYTES; i++)
        begin
            if (value[i*8 +: 8] != vlne_pkg::ZERO_BYTE)
            begin
                is_short = 1'b0;
            end
        end

        if (compact)
        begin
            s = vlne_pkg::len_t'(1);
            u = vlne_pkg::len_t'(1);
            for (int i = 0; i < VALUE_BYTES; i++)
            begin
                b = value[i*8 +: 8];
                if (b != vlne_pkg::ZERO_BYTE)
                begin
                    s = vlne_pkg::len_t'(i + 1);
                end
                if (b != vlne_pkg::FILL_BYTE)
                begin
                    u = vlne_pkg::len_t'(i + 1);
                end
            end
        end
        else
        begin
            b = vlne_pkg::ZERO_BYTE;
            s = vlne_pkg::len_t'(VALUE_BYTES);
            u = vlne_pkg::len_t'(VALUE_BYTES);
        end

        if (is_short)
        begin
            plan.head = value[7:0];
            plan.len  = '0;
        end
        else if (u < s)
        begin
            plan.head = vlne_pkg::HEAD_FILL + vlne_pkg::byte_t'(u);
            plan.len  = u;
        end
        else
        begin
            plan.head = vlne_pkg::HEAD_PLAIN + vlne_pkg::byte_t'(s);
            plan.len  = s;
        end
    end

endmodule

// ----- design/vlne_serializer.sv -----
// holds one planned encoding and sends it out a byte at a time
module vlne_serializer #(
    parameter int VALUE_BYTES = vlne_pkg::MAX_BYTES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_valid,
    input  logic [VALUE_BYTES*8-1:0] load_value,
    input  vlne_pkg::vlne_plan_t     load_plan,
    output logic                     load_ok,
    vlne_result_if.source            result
);

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               out_byte_reg;
    logic [7:0]               out_byte_next;
    logic                     out_last_reg;
    logic                     out_last_next;
    logic [VALUE_BYTES*8-1:0] data_reg;
    logic [VALUE_BYTES*8-1:0] data_next;
    vlne_pkg::len_t           remain_reg;
    vlne_pkg::len_t           remain_next;
    logic                     fire;

    assign fire    = out_valid_reg && result.ready;
    assign load_ok = !out_valid_reg || (fire && (remain_reg == '0));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        data_next      = data_reg;
        remain_next    = remain_reg;
        if (load_ok && load_valid)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = load_plan.head;
            out_last_next  = (load_plan.len == '0);
            data_next      = load_value;
            remain_next    = load_plan.len;
        end
        else if (load_ok)
        begin
            out_valid_next = 1'b0;
        end
        else if (fire)
        begin
            // next data byte, low byte first
            out_byte_next = data_reg[7:0];
            out_last_next = (remain_reg == vlne_pkg::len_t'(1));
            data_next     = data_reg >> 8;
            remain_next   = remain_reg - vlne_pkg::len_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        data_reg     <= data_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;

endmodule
